>>> src/lmsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmsp_pkg
// Shared types and constants for the LED matrix sample plotter.
// ----------------------------------------------------------------------------
package lmsp_pkg;

    localparam int unsigned NUM_COLS  = 16;
    localparam int unsigned NUM_ROWS  = 4;
    localparam int unsigned COL_W     = 4;
    localparam int unsigned ROW_W     = 2;
    localparam int unsigned STEP_W    = 6;

    localparam logic [COL_W-1:0]  COL_LAST   = 4'd15;
    localparam logic [STEP_W-1:0] STEP_WAIT  = 6'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 6'd1;

    // display commands
    localparam logic [7:0] CMD_LEFT_GREEN   = 8'hB0;
    localparam logic [7:0] CMD_LEFT_ORANGE  = 8'hB2;
    localparam logic [7:0] CMD_RIGHT_GREEN  = 8'hB1;
    localparam logic [7:0] CMD_RIGHT_ORANGE = 8'hB3;

    typedef enum logic {
        OP_WAIT,
        OP_EMIT
    } t_op;

    // one microcode control word
    typedef struct packed {
        t_op              op;
        logic             is_cmd;     // emit cmd instead of a data byte
        logic [7:0]       cmd;
        logic [COL_W-1:0] col;        // column of the data byte
        logic             orange;     // orange plane
        logic             has_extra;  // bit 0 carries a column 14/15 pixel
        logic             extra_c15;  // extra pixel in last column, else col 14
        logic [ROW_W-1:0] extra_row;
        logic             last;       // final byte of burst, return to wait
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        logic accept;   // sample request taken this cycle
        logic clear;    // wipe store and column after burst
    } t_dp_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic hit;      // row differs from last plotted row
        logic wrap;     // column counter sits on the last column
    } t_dp_status;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[b] = v[7-b];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/lmsp_ucode_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmsp_ucode_rom
// Render program: one control word per step, wait step then 32 byte steps.
// ----------------------------------------------------------------------------
module lmsp_ucode_rom (
    input  wire logic [lmsp_pkg::STEP_W-1:0] i_step,
    output lmsp_pkg::t_uword                 o_uword
);

    function automatic lmsp_pkg::t_uword emit_cmd(input logic [7:0] c);
        lmsp_pkg::t_uword w;
        w           = '0;
        w.op        = lmsp_pkg::OP_EMIT;
        w.is_cmd    = 1'b1;
        w.cmd       = c;
        return w;
    endfunction

    function automatic lmsp_pkg::t_uword emit_data(
        input logic [3:0] col,
        input logic       orange,
        input logic       has_x,
        input logic       x15,
        input logic [1:0] xrow,
        input logic       last
    );
        lmsp_pkg::t_uword w;
        w           = '0;
        w.op        = lmsp_pkg::OP_EMIT;
        w.col       = col;
        w.orange    = orange;
        w.has_extra = has_x;
        w.extra_c15 = x15;
        w.extra_row = xrow;
        w.last      = last;
        return w;
    endfunction

    always_comb begin
        o_uword    = '0;
        o_uword.op = lmsp_pkg::OP_WAIT;
        case (i_step)
            // left green
            6'd1:  o_uword = emit_cmd(lmsp_pkg::CMD_LEFT_GREEN);
            6'd2:  o_uword = emit_data(4'd0,  1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd3:  o_uword = emit_data(4'd1,  1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd4:  o_uword = emit_data(4'd2,  1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd5:  o_uword = emit_data(4'd3,  1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd6:  o_uword = emit_data(4'd4,  1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd7:  o_uword = emit_data(4'd5,  1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd8:  o_uword = emit_data(4'd6,  1'b0, 1'b1, 1'b0, 2'd3, 1'b0);
            // left orange
            6'd9:  o_uword = emit_cmd(lmsp_pkg::CMD_LEFT_ORANGE);
            6'd10: o_uword = emit_data(4'd0,  1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd11: o_uword = emit_data(4'd1,  1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd12: o_uword = emit_data(4'd2,  1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd13: o_uword = emit_data(4'd3,  1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd14: o_uword = emit_data(4'd4,  1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd15: o_uword = emit_data(4'd5,  1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
            6'd16: o_uword = emit_data(4'd6,  1'b1, 1'b1, 1'b0, 2'd3, 1'b0);
            // right green
            6'd17: o_uword = emit_cmd(lmsp_pkg::CMD_RIGHT_GREEN);
            6'd18: o_uword = emit_data(4'd7,  1'b0, 1'b1, 1'b1, 2'd3, 1'b0);
            6'd19: o_uword = emit_data(4'd8,  1'b0, 1'b1, 1'b1, 2'd2, 1'b0);
            6'd20: o_uword = emit_data(4'd9,  1'b0, 1'b1, 1'b0, 2'd2, 1'b0);
            6'd21: o_uword = emit_data(4'd10, 1'b0, 1'b1, 1'b1, 2'd0, 1'b0);
            6'd22: o_uword = emit_data(4'd11, 1'b0, 1'b1, 1'b1, 2'd1, 1'b0);
            6'd23: o_uword = emit_data(4'd12, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0);
            6'd24: o_uword = emit_data(4'd13, 1'b0, 1'b1, 1'b0, 2'd1, 1'b0);
            // right orange
            6'd25: o_uword = emit_cmd(lmsp_pkg::CMD_RIGHT_ORANGE);
            6'd26: o_uword = emit_data(4'd7,  1'b1, 1'b1, 1'b1, 2'd3, 1'b0);
            6'd27: o_uword = emit_data(4'd8,  1'b1, 1'b1, 1'b1, 2'd2, 1'b0);
            6'd28: o_uword = emit_data(4'd9,  1'b1, 1'b1, 1'b0, 2'd2, 1'b0);
            6'd29: o_uword = emit_data(4'd10, 1'b1, 1'b1, 1'b1, 2'd0, 1'b0);
            6'd30: o_uword = emit_data(4'd11, 1'b1, 1'b1, 1'b1, 2'd1, 1'b0);
            6'd31: o_uword = emit_data(4'd12, 1'b1, 1'b1, 1'b0, 2'd0, 1'b0);
            6'd32: o_uword = emit_data(4'd13, 1'b1, 1'b1, 1'b0, 2'd1, 1'b1);
            default: begin
                o_uword    = '0;
                o_uword.op = lmsp_pkg::OP_WAIT;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/lmsp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmsp_datapath
// Pixel store, column and row tracking, and display byte assembly.
// ----------------------------------------------------------------------------
module lmsp_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_sample,
    input  wire lmsp_pkg::t_dp_ctrl   i_ctrl,
    input  wire lmsp_pkg::t_uword     i_uword,
    output lmsp_pkg::t_dp_status      o_status,
    output logic [7:0]                o_byte
);

    // green plane, one row nibble per column; the orange plane is never
    // written by the plotter and reads as zero
    logic [lmsp_pkg::NUM_ROWS-1:0] r_col [lmsp_pkg::NUM_COLS];
    logic [lmsp_pkg::COL_W-1:0]    r_column;
    logic [lmsp_pkg::ROW_W-1:0]    r_last_row;

    logic [lmsp_pkg::ROW_W-1:0]    row;
    logic [lmsp_pkg::NUM_ROWS-1:0] col_bits;
    logic                          extra;
    logic [7:0]                    raw;

    assign row           = ~i_sample[7:6];   // 3 - sample/64
    assign o_status.hit  = (row != r_last_row);
    assign o_status.wrap = (r_column == lmsp_pkg::COL_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < lmsp_pkg::NUM_COLS; c++) begin
                r_col[c] <= '0;
            end
            r_column   <= '0;
            r_last_row <= '0;
        end else if (i_ctrl.clear) begin
            for (int c = 0; c < lmsp_pkg::NUM_COLS; c++) begin
                r_col[c] <= '0;
            end
            r_column <= '0;
        end else if (i_ctrl.accept && o_status.hit) begin
            r_col[r_column][row] <= 1'b1;
            r_last_row           <= row;
            if (!o_status.wrap) begin
                r_column <= r_column + 4'd1;
            end
        end
    end

    always_comb begin
        col_bits = i_uword.orange ? '0 : r_col[i_uword.col];
        extra    = i_uword.has_extra && !i_uword.orange &&
                   (i_uword.extra_c15 ? r_col[15][i_uword.extra_row]
                                      : r_col[14][i_uword.extra_row]);
        raw      = i_uword.is_cmd ? i_uword.cmd : {3'b000, col_bits, extra};
        o_byte   = lmsp_pkg::reverse8(raw);
    end

endmodule
`default_nettype wire

>>> src/led_matrix_sample_plotter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_sample_plotter_unit
// Plots 8-bit samples onto a 4x16 two-color LED matrix frame and renders it.
// ----------------------------------------------------------------------------
// Each sample request picks a row (3 minus the top two sample bits). A sample
// whose row matches the last plotted row is dropped; otherwise its green
// pixel is set at the current column and the column advances. When the
// sixteenth column has been plotted the block renders the frame as a 32-byte
// burst (four command bytes, each followed by seven column bytes, all
// bit-reversed for LSB-first shifting), then wipes the frame and restarts at
// column 0. The burst is played by a microcoded sequencer: a 33-step program
// ROM, one control word per step, one byte per cycle when the output side
// does not stall. Input requests are held off for the whole burst; the
// output register lets the last byte wait while the next sample is taken.
// o_last_byte flags the final byte of a burst.
// ----------------------------------------------------------------------------
module led_matrix_sample_plotter_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // sample channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_sample,
    // display byte channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_wire_byte,
    output logic            o_last_byte
);

    logic [lmsp_pkg::STEP_W-1:0] r_step;
    logic [lmsp_pkg::STEP_W-1:0] n_step;

    lmsp_pkg::t_uword     uword;
    lmsp_pkg::t_dp_ctrl   dp_ctrl;
    lmsp_pkg::t_dp_status dp_status;
    logic [7:0]           dp_byte;

    logic accept;
    logic advance;

    lmsp_ucode_rom u_rom (
        .i_step  (r_step),
        .o_uword (uword)
    );

    lmsp_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_ctrl   (dp_ctrl),
        .i_uword  (uword),
        .o_status (dp_status),
        .o_byte   (dp_byte)
    );

    // requests only in the wait step
    assign o_in_stall = (uword.op != lmsp_pkg::OP_WAIT);
    assign accept     = i_in_valid && !o_in_stall;

    // a byte step moves on when the output register is free or draining
    assign advance = (uword.op == lmsp_pkg::OP_EMIT) && (!o_out_valid || !i_out_stall);

    assign dp_ctrl.accept = accept;
    assign dp_ctrl.clear  = advance && uword.last;

    // step counter with the two jumps: into the burst and back to wait
    always_comb begin
        n_step = r_step;
        if (accept && dp_status.hit && dp_status.wrap) begin
            n_step = lmsp_pkg::STEP_FIRST;
        end else if (advance) begin
            n_step = uword.last ? lmsp_pkg::STEP_WAIT : r_step + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= lmsp_pkg::STEP_WAIT;
            o_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (advance) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_wire_byte <= dp_byte;
            o_last_byte <= uword.last;
        end
    end

endmodule
`default_nettype wire
